// ----- rtl/rlpg_pkg.sv -----
// Shared widths and codes for the raster line point generator.
package rlpg_pkg;

	localparam int COORD_BITS = 10;
	localparam int ERR_BITS   = COORD_BITS + 1;
	localparam int COLOR_BITS = 16;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_PLUS  = 2'd1;
	localparam logic [1:0] DIR_MINUS = 2'd3;

endpackage

// ----- rtl/rlpg_cmd_if.sv -----
// Command channel: start and step commands with line endpoints and color.
interface rlpg_cmd_if;
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic [rlpg_pkg::COORD_BITS-1:0] x_start;
	logic [rlpg_pkg::COORD_BITS-1:0] y_start;
	logic [rlpg_pkg::COORD_BITS-1:0] x_end;
	logic [rlpg_pkg::COORD_BITS-1:0] y_end;
	logic [rlpg_pkg::COLOR_BITS-1:0] color;

	modport source (output valid, command, x_start, y_start, x_end, y_end, color,
		input ready);
	modport sink (input valid, command, x_start, y_start, x_end, y_end, color,
		output ready);
endinterface

// ----- rtl/rlpg_pt_if.sv -----
// Point channel: one pixel position and color per transfer.
interface rlpg_pt_if;
	logic                           valid;
	logic                           ready;
	logic [rlpg_pkg::COORD_BITS-1:0] point_x;
	logic [rlpg_pkg::COORD_BITS-1:0] point_y;
	logic [rlpg_pkg::COLOR_BITS-1:0] pixel_color;
	logic                           last_point;

	modport source (output valid, point_x, point_y, pixel_color, last_point,
		input ready);
	modport sink (input valid, point_x, point_y, pixel_color, last_point,
		output ready);
endinterface

// ----- rtl/raster_line_point_generator_top.sv -----
// Raster line point generator: Bresenham stepping, one pixel per step command.
//
// Channels: cmd (sink) takes commands, pt (source) delivers pixels. Both use
// valid/ready; a transfer happens on a clock edge with both high.
// A start command loads endpoints and color and delivers nothing. Each step
// command then delivers one pixel; a line gives its major distance plus two
// pixels (the first repeats), the final one with last_point set. A step with
// no line in progress delivers nothing.
// Output: a pixel is registered and appears on pt in the cycle after its step command transfers.
// Throughput: one command per cycle unless the receiver stalls, set by the error
// update on the registered error terms and the one-entry output register.
// When the receiver stalls, the pending pixel holds in the output register and
// cmd.ready drops until it is taken; cmd.ready stays high in a cycle in which
// the pending pixel transfers, so commands keep flowing back to back.
// Reset (arst_n low) clears all line state and empties the output register;
// the block is idle afterwards.
module raster_line_point_generator_top (
	input  logic         clk,
	input  logic         arst_n,
	rlpg_cmd_if.sink     cmd,
	rlpg_pt_if.source    pt
);

	localparam int CB = rlpg_pkg::COORD_BITS;
	localparam int EB = rlpg_pkg::ERR_BITS;

	logic [CB-1:0] cur_col_q, cur_row_q;
	logic [EB-1:0] col_error_q, row_error_q;
	logic [CB-1:0] abs_dcol_q, abs_drow_q, major_dist_q;
	logic [1:0]    col_dir_q, row_dir_q;
	logic [EB-1:0] points_left_q;
	logic [rlpg_pkg::COLOR_BITS-1:0] line_color_q;
	logic          busy_q;

	logic          pt_valid_q;
	logic [CB-1:0] pt_x_q, pt_y_q;
	logic [rlpg_pkg::COLOR_BITS-1:0] pt_color_q;
	logic          pt_last_q;

	logic          accept, do_start, do_step;
	logic [CB-1:0] dcol, drow, dmajor;
	logic [1:0]    cdir, rdir;
	logic [EB-1:0] col_sum, row_sum;
	logic          col_adv, row_adv;
	logic [EB-1:0] points_next;

	function automatic logic [CB-1:0] axis_move(input logic [CB-1:0] pos,
		input logic [1:0] dir);
		logic [CB-1:0] res;
		case (dir)
			rlpg_pkg::DIR_PLUS:  res = pos + CB'(1);
			rlpg_pkg::DIR_MINUS: res = pos - CB'(1);
			default:             res = pos;
		endcase
		return res;
	endfunction

	assign cmd.ready = !pt_valid_q || pt.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign do_start  = accept && (cmd.command == rlpg_pkg::CMD_START);
	assign do_step   = accept && (cmd.command == rlpg_pkg::CMD_STEP) && busy_q;

	// deltas and directions of a new line
	always_comb begin
		if (cmd.x_end > cmd.x_start) begin
			dcol = cmd.x_end - cmd.x_start;
			cdir = rlpg_pkg::DIR_PLUS;
		end else if (cmd.x_end < cmd.x_start) begin
			dcol = cmd.x_start - cmd.x_end;
			cdir = rlpg_pkg::DIR_MINUS;
		end else begin
			dcol = '0;
			cdir = rlpg_pkg::DIR_NONE;
		end
		if (cmd.y_end > cmd.y_start) begin
			drow = cmd.y_end - cmd.y_start;
			rdir = rlpg_pkg::DIR_PLUS;
		end else if (cmd.y_end < cmd.y_start) begin
			drow = cmd.y_start - cmd.y_end;
			rdir = rlpg_pkg::DIR_MINUS;
		end else begin
			drow = '0;
			rdir = rlpg_pkg::DIR_NONE;
		end
		dmajor = (dcol > drow) ? dcol : drow;
	end

	// error update of one step
	assign col_sum     = col_error_q + EB'(abs_dcol_q);
	assign row_sum     = row_error_q + EB'(abs_drow_q);
	assign col_adv     = col_sum > EB'(major_dist_q);
	assign row_adv     = row_sum > EB'(major_dist_q);
	assign points_next = points_left_q - EB'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			col_error_q   <= '0;
			row_error_q   <= '0;
			abs_dcol_q    <= '0;
			abs_drow_q    <= '0;
			major_dist_q  <= '0;
			col_dir_q     <= rlpg_pkg::DIR_NONE;
			row_dir_q     <= rlpg_pkg::DIR_NONE;
			points_left_q <= '0;
			line_color_q  <= '0;
			busy_q        <= 1'b0;
		end else if (do_start) begin
			cur_col_q     <= cmd.x_start;
			cur_row_q     <= cmd.y_start;
			col_error_q   <= '0;
			row_error_q   <= '0;
			abs_dcol_q    <= dcol;
			abs_drow_q    <= drow;
			major_dist_q  <= dmajor;
			col_dir_q     <= cdir;
			row_dir_q     <= rdir;
			points_left_q <= EB'(dmajor) + EB'(2);
			line_color_q  <= cmd.color;
			busy_q        <= 1'b1;
		end else if (do_step) begin
			col_error_q   <= col_adv ? col_sum - EB'(major_dist_q) : col_sum;
			row_error_q   <= row_adv ? row_sum - EB'(major_dist_q) : row_sum;
			if (col_adv) begin
				cur_col_q <= axis_move(cur_col_q, col_dir_q);
			end
			if (row_adv) begin
				cur_row_q <= axis_move(cur_row_q, row_dir_q);
			end
			points_left_q <= points_next;
			if (points_next == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid_q <= 1'b0;
		end else if (do_step) begin
			pt_valid_q <= 1'b1;
		end else if (pt.ready) begin
			pt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			pt_x_q     <= cur_col_q;
			pt_y_q     <= cur_row_q;
			pt_color_q <= line_color_q;
			pt_last_q  <= (points_left_q == EB'(1));
		end
	end

	assign pt.valid       = pt_valid_q;
	assign pt.point_x     = pt_x_q;
	assign pt.point_y     = pt_y_q;
	assign pt.pixel_color = pt_color_q;
	assign pt.last_point  = pt_last_q;

endmodule

// ----- rtl/rlpg_checker.sv -----
// Port-level assertions for the raster line point generator, bound to the top level.
module rlpg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_valid,
	input logic                            cmd_ready,
	input logic                            cmd_command,
	input logic                            pt_valid,
	input logic                            pt_ready,
	input logic [rlpg_pkg::COORD_BITS-1:0] pt_x,
	input logic [rlpg_pkg::COORD_BITS-1:0] pt_y,
	input logic [rlpg_pkg::COLOR_BITS-1:0] pt_color,
	input logic                            pt_last
);

	// a stalled pixel stays offered
	a_pt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_ready |=> pt_valid)
		else $error("pixel dropped while stalled");

	// a stalled pixel keeps its payload
	a_pt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_ready |=> $stable(pt_x) && $stable(pt_y)
			&& $stable(pt_color) && $stable(pt_last))
		else $error("pixel payload changed while stalled");

	// a new pixel follows only a step command transfer
	a_pt_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !($past(pt_valid) && !$past(pt_ready)) |->
			$past(cmd_valid && cmd_ready && (cmd_command == rlpg_pkg::CMD_STEP)))
		else $error("pixel without a step command");

	// a start command delivers nothing
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_command == rlpg_pkg::CMD_START) |=> !pt_valid)
		else $error("pixel after a start command");

	// no command is taken while a pixel waits on a stalled receiver
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_ready |-> !cmd_ready)
		else $error("command taken while output is full");

endmodule

bind raster_line_point_generator_top rlpg_checker u_rlpg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_command (cmd.command),
	.pt_valid    (pt.valid),
	.pt_ready    (pt.ready),
	.pt_x        (pt.point_x),
	.pt_y        (pt.point_y),
	.pt_color    (pt.pixel_color),
	.pt_last     (pt.last_point)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the raster line point generator: predicts every pixel and compares.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB           = rlpg_pkg::COORD_BITS;
	localparam int EB           = rlpg_pkg::ERR_BITS;
	localparam int COLB         = rlpg_pkg::COLOR_BITS;
	localparam int MAX_COORD    = (1 << CB) - 1;
	localparam int RANDOM_ITEMS = 600;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic [CB-1:0]   x;
		logic [CB-1:0]   y;
		logic [COLB-1:0] color;
		logic            last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;

	rlpg_cmd_if cmd ();
	rlpg_pt_if  pt ();

	raster_line_point_generator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pt     (pt)
	);

	always #2 clk = ~clk;

	// Line tracer state
	logic [CB-1:0]   pen_col, pen_row;
	logic [EB-1:0]   col_acc, row_acc;
	logic [CB-1:0]   run_col, run_row, major_run;
	logic [1:0]      col_step, row_step;
	logic [EB-1:0]   pixels_left;
	logic [COLB-1:0] ink;
	logic            drawing;

	pixel_t expected_pixels[$];

	int mismatches     = 0;
	int pixels_checked = 0;
	int lines_started  = 0;
	int idle_steps     = 0;
	int useful_cmds    = 0;
	int cmd_transfers  = 0;
	int cycle_count    = 0;
	int send_gap_max   = 17;
	int stall_max      = 17;
	logic hold_req     = 1'b0;
	logic hold_on      = 1'b0;

	function automatic logic [CB-1:0] axis_span(input logic [CB-1:0] from_pos,
			input logic [CB-1:0] to_pos, output logic [1:0] dir);
		if (to_pos > from_pos) begin
			dir = rlpg_pkg::DIR_PLUS;
			return to_pos - from_pos;
		end
		if (to_pos < from_pos) begin
			dir = rlpg_pkg::DIR_MINUS;
			return from_pos - to_pos;
		end
		dir = rlpg_pkg::DIR_NONE;
		return '0;
	endfunction

	function automatic logic [CB-1:0] nudge(input logic [CB-1:0] pos,
			input logic [1:0] dir);
		if (dir == rlpg_pkg::DIR_PLUS)
			return pos + CB'(1);
		if (dir == rlpg_pkg::DIR_MINUS)
			return pos - CB'(1);
		return pos;
	endfunction

	function automatic int clamp_coord(input int v);
		return (v < 0) ? 0 : ((v > MAX_COORD) ? MAX_COORD : v);
	endfunction

	task automatic trace_command(input logic op, input logic [CB-1:0] xs, ys, xe, ye,
			input logic [COLB-1:0] color);
		pixel_t px;
		if (op == rlpg_pkg::CMD_START) begin
			pen_col   = xs;
			pen_row   = ys;
			run_col   = axis_span(xs, xe, col_step);
			run_row   = axis_span(ys, ye, row_step);
			major_run = (run_col > run_row) ? run_col : run_row;
			col_acc   = '0;
			row_acc   = '0;
			pixels_left = {1'b0, major_run} + EB'(2);
			ink       = color;
			drawing   = 1'b1;
			lines_started++;
			useful_cmds++;
		end else if (drawing) begin
			px.x     = pen_col;
			px.y     = pen_row;
			px.color = ink;
			px.last  = (pixels_left == EB'(1));
			expected_pixels.push_back(px);
			col_acc = col_acc + EB'(run_col);
			row_acc = row_acc + EB'(run_row);
			if (col_acc > EB'(major_run)) begin
				col_acc = col_acc - EB'(major_run);
				pen_col = nudge(pen_col, col_step);
			end
			if (row_acc > EB'(major_run)) begin
				row_acc = row_acc - EB'(major_run);
				pen_row = nudge(pen_row, row_step);
			end
			pixels_left = pixels_left - EB'(1);
			if (pixels_left == '0)
				drawing = 1'b0;
			useful_cmds++;
		end else begin
			idle_steps++;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("tb_top: mismatch at cycle %0d: %s got %0d expected %0d",
				cycle_count, what, got, want);
	endtask

	// Predict on every command transfer
	always @(posedge clk) begin
		if (arst_n && cmd.valid && cmd.ready) begin
			cmd_transfers++;
			trace_command(cmd.command, cmd.x_start, cmd.y_start, cmd.x_end, cmd.y_end,
				cmd.color);
		end
	end

	// Compare every pixel transfer with the oldest prediction
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && pt.valid && pt.ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("pixel with none pending, x", pt.point_x, -1);
			end else begin
				want = expected_pixels.pop_front();
				pixels_checked++;
				if (pt.point_x !== want.x)
					report_mismatch("point_x", pt.point_x, want.x);
				if (pt.point_y !== want.y)
					report_mismatch("point_y", pt.point_y, want.y);
				if (pt.pixel_color !== want.color)
					report_mismatch("pixel_color", pt.pixel_color, want.color);
				if (pt.last_point !== want.last)
					report_mismatch("last_point", pt.last_point, want.last);
			end
		end
	end

	// Long receiver hold: count the stretch on request
	initial begin : long_hold
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		end
	end

	// Pixel receiver: random stall per transfer, dropped ready while the long hold runs
	initial begin : pixel_sink
		int stall_left;
		stall_left = 0;
		pt.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				pt.ready <= 1'b0;
			end else begin
				if (hold_on) begin
					pt.ready <= 1'b0;
				end else if (pt.valid && pt.ready) begin
					stall_left = $urandom_range(0, stall_max);
					pt.ready <= (stall_left == 0);
				end else if (stall_left != 0) begin
					stall_left--;
					pt.ready <= (stall_left == 0);
				end else begin
					pt.ready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: timeout after %0d cycles, %0d pixels still pending",
			cycle_count, expected_pixels.size());
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic send_cmd(input logic op, input int xs, ys, xe, ye, color);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid   <= 1'b1;
		cmd.command <= op;
		cmd.x_start <= xs[CB-1:0];
		cmd.y_start <= ys[CB-1:0];
		cmd.x_end   <= xe[CB-1:0];
		cmd.y_end   <= ye[CB-1:0];
		cmd.color   <= color[COLB-1:0];
		do @(posedge clk); while (!cmd.ready);
	endtask

	// Start a line, then issue its full point count plus extra steps (negative cuts it short).
	task automatic draw_line(input int xs, ys, xe, ye, color, extra);
		int dx, dy, steps;
		dx = (xe > xs) ? xe - xs : xs - xe;
		dy = (ye > ys) ? ye - ys : ys - ye;
		steps = ((dx > dy) ? dx : dy) + 2 + extra;
		send_cmd(rlpg_pkg::CMD_START, xs, ys, xe, ye, color);
		repeat (steps)
			send_cmd(rlpg_pkg::CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_idle_step();
		repeat (2) send_cmd(rlpg_pkg::CMD_STEP, MAX_COORD, 0, MAX_COORD, 0, 16'hFFFF);
	endtask

	task automatic test_equal_endpoints();
		draw_line(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 16'hFFFF, 1);
	endtask

	task automatic test_edge_lines();
		draw_line(0, 0, 2, 1, 16'h0000, 0);
		draw_line(MAX_COORD, MAX_COORD, MAX_COORD - 1, MAX_COORD - 3, 16'h8421, 0);
	endtask

	task automatic test_restart();
		// drop this line after two points
		draw_line(5, 5, 9, 5, 16'h07E0, -4);
		draw_line(9, 9, 9, 7, 16'hF81F, 0);
	endtask

	task automatic test_full_span();
		send_gap_max = 3;
		stall_max    = 3;
		draw_line(MAX_COORD, 0, 0, MAX_COORD, $urandom, 0);
		draw_line(0, MAX_COORD, 300, 900, $urandom, 0);
	endtask

	task automatic test_output_stall();
		send_gap_max = 0;
		stall_max    = 0;
		hold_req = 1'b1;
		wait (hold_on);
		draw_line(100, 200, 130, 190, $urandom, 0);
	endtask

	task automatic test_random_lines();
		int goal, mode_at, xs, ys, xe, ye, reach, dx, dy, full, extra;
		goal    = useful_cmds + RANDOM_ITEMS;
		mode_at = 0;
		while (useful_cmds < goal) begin
			if (useful_cmds >= mode_at) begin
				case ($urandom_range(0, 3))
					0: begin send_gap_max = 0;  stall_max = 0;  end
					1: begin send_gap_max = 17; stall_max = 0;  end
					2: begin send_gap_max = 0;  stall_max = 17; end
					default: begin send_gap_max = 17; stall_max = 17; end
				endcase
				mode_at = useful_cmds + 200;
			end
			if ($urandom_range(0, 99) < 85) begin
				reach = ($urandom_range(0, 49) == 0) ? MAX_COORD : 24;
				xs = $urandom_range(0, MAX_COORD);
				ys = $urandom_range(0, MAX_COORD);
				xe = clamp_coord(xs + int'($urandom_range(0, 2 * reach)) - reach);
				ye = clamp_coord(ys + int'($urandom_range(0, 2 * reach)) - reach);
				dx = (xe > xs) ? xe - xs : xs - xe;
				dy = (ye > ys) ? ye - ys : ys - ye;
				full = ((dx > dy) ? dx : dy) + 2;
				extra = 0;
				if ($urandom_range(0, 9) == 0)
					extra = -int'($urandom_range(1, full));
				else if ($urandom_range(0, 9) == 0)
					extra = $urandom_range(1, 3);
				draw_line(xs, ys, xe, ye, $urandom, extra);
			end else begin
				repeat ($urandom_range(1, 4))
					send_cmd(($urandom_range(0, 1) != 0) ? rlpg_pkg::CMD_STEP
						: rlpg_pkg::CMD_START,
						$urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cmd.valid   <= 1'b0;
		cmd.command <= rlpg_pkg::CMD_START;
		cmd.x_start <= '0;
		cmd.y_start <= '0;
		cmd.x_end   <= '0;
		cmd.y_end   <= '0;
		cmd.color   <= '0;
		drawing     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_step();
		test_equal_endpoints();
		test_edge_lines();
		test_restart();
		test_full_span();
		test_output_stall();
		test_random_lines();

		cmd.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d command transfers, %0d lines started, %0d steps with no line",
			cmd_transfers, lines_started, idle_steps);
		$display("tb_top: %0d pixels compared over %0d cycles, one %0d-cycle output hold",
			pixels_checked, cycle_count, HOLD_CYCLES);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
